### src/nsf_pkg.sv
package nsf_pkg;

    // defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 16;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int OFF_W     = 16;
    localparam int OCC_W     = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PATTERN_LOW    = 2'd0;
    localparam cfg_idx_t REG_PATTERN_HIGH   = 2'd1;
    localparam cfg_idx_t REG_PATTERN_LENGTH = 2'd2;
    localparam cfg_idx_t REG_OCCURRENCE     = 2'd3;

    // one result item: the found flag carried on tuser, then the result channel tdata fields without the zero fill
    typedef struct packed {
        logic             found;
        logic             overflow;
        logic [LEN_W-1:0] match_length;
        logic [OFF_W-1:0] match_offset;
    } result_t;

endpackage

### src/nsf_window_match.sv
module nsf_window_match #(
    parameter int PATTERN_MAX = nsf_pkg::PATTERN_MAX_DEF,
    parameter int WIN_SLOTS   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1
) (
    input  logic [nsf_pkg::BYTE_W-1:0]                    cur_byte,
    input  logic [nsf_pkg::BYTE_W-1:0]                    window [WIN_SLOTS],
    input  logic [nsf_pkg::PAT_BYTES*nsf_pkg::BYTE_W-1:0] pattern,
    input  logic [nsf_pkg::LEN_W-1:0]                     len,
    output logic                                          hit
);
    import nsf_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [BYTE_W-1:0] seq   [PATTERN_MAX];
    logic [BYTE_W-1:0] pat_b [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;

    // seq[0] is the newest byte, seq[k] the byte k places back
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_seq
        if (g == 0) begin : g_cur
            assign seq[g] = cur_byte;
        end else begin : g_win
            assign seq[g] = window[g-1];
        end
        if (g < PAT_BYTES) begin : g_pat
            assign pat_b[g] = pattern[g*BYTE_W +: BYTE_W];
        end else begin : g_zero
            assign pat_b[g] = '0;
        end
    end

    // pattern byte i lines up with the byte len-1-i places back
    always_comb begin
        logic [IDX_W-1:0] sel;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            sel = IDX_W'(32'(len) - 32'(i) - 32'd1);
            if (32'(i) < 32'(len)) begin
                eq[i] = (seq[sel] == pat_b[i]);
            end else begin
                eq[i] = 1'b1;
            end
        end
        hit = &eq;
    end

endmodule

### src/nth_substring_finder_top.sv
// channel   | dir | tvalid/tready       | tdata (low bit first)                  | tuser / tlast
// ----------+-----+---------------------+----------------------------------------+--------------
// s_ text   | in  | s_tvalid / s_tready | text_byte[7:0]                         | tlast=last_byte
// m_ result | out | m_tvalid / m_tready | match_offset[15:0] match_length[20:16] | tuser=found
//           |     |                     | overflow[21], zero fill [23:22]        |
// cfg       | in  | cfg_we              | cfg_index selects, cfg_wdata 64 bits   | -
//
// one text item per cycle sustained while no held result stalls it; an item waits in the input register and its
// result, if any, is written into the result register when the item advances
// the byte compare against the pattern is a single parallel window compare, so nothing iterates
// aresetn is synchronous, active low; it clears the handshake state, the stream state and the
// configuration registers (length 1, occurrence 1, pattern all zero)
// a held result stalls the input register behind it; a last byte clears the search state
module nth_substring_finder_top #(
    parameter int PATTERN_MAX  = nsf_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_WIDTH = nsf_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // text item channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsf_pkg::S_DATA_W-1:0]  s_tdata,   // text_byte[7:0]
    input  logic                          s_tlast,   // last_byte
    // result item channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsf_pkg::M_DATA_W-1:0]  m_tdata,   // match_offset, match_length, overflow, 0
    output logic                          m_tuser,   // found
    // configuration writes
    input  logic                          cfg_we,
    input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsf_pkg::CFG_W-1:0]     cfg_wdata
);
    import nsf_pkg::*;

    localparam int WIN_SLOTS = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int EXT_W     = (OFFSET_WIDTH > OFF_W) ? OFFSET_WIDTH : OFF_W;
    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

    // configuration registers
    logic [CFG_W-1:0] pattern_low_reg;
    logic [CFG_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [OCC_W-1:0] occurrence_reg;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // stream state
    logic [BYTE_W-1:0]       history_reg [WIN_SLOTS];
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OCC_W-1:0]        matches_reg, matches_next;
    logic                    reported_reg, reported_next;
    logic                    pos_ovf_reg, pos_ovf_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic                 advance;
    logic [LEN_W-1:0]     len_eff;
    logic                 hit;
    logic                 in_range;
    logic                 hit_ok;
    logic [OCC_W-1:0]     cnt_inc;
    logic                 report;
    logic                 not_found;
    logic                 ovf_now;
    logic [OFFSET_WIDTH-1:0] start_pos;
    logic [EXT_W-1:0]     start_ext;

    // the held item moves on unless the result slot is full and not being taken, whether or not the item has a result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // lengths beyond the window are clamped
    assign len_eff = (32'(pattern_length_reg) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                             : pattern_length_reg;

    nsf_window_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .WIN_SLOTS   (WIN_SLOTS)
    ) u_match (
        .cur_byte (in_byte_reg),
        .window   (history_reg),
        .pattern  ({pattern_high_reg, pattern_low_reg}),
        .len      (len_eff),
        .hit      (hit)
    );

    always_comb begin
        // enough bytes of this text seen to hold a whole pattern
        in_range  = ((OFFSET_WIDTH+1)'(pos_reg) + 1'b1) >= (OFFSET_WIDTH+1)'(len_eff);
        hit_ok    = !reported_reg && (len_eff != '0) && in_range && hit;
        cnt_inc   = (matches_reg == '1) ? matches_reg : matches_reg + 1'b1;
        report    = hit_ok && (occurrence_reg != '0) && (cnt_inc == occurrence_reg);
        not_found = in_last_reg && !reported_reg && !report;
        ovf_now   = pos_ovf_reg || (pos_reg == POS_MAX);
        start_pos = pos_reg - OFFSET_WIDTH'(len_eff) + 1'b1;
        start_ext = EXT_W'(start_pos);

        out_next.found        = report;
        out_next.overflow     = ovf_now;
        out_next.match_length = report ? len_eff : '0;
        out_next.match_offset = report ? start_ext[OFF_W-1:0] : '0;

        matches_next  = hit_ok ? cnt_inc : matches_reg;
        reported_next = reported_reg || report;
        pos_ovf_next  = ovf_now;
        pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance && (report || not_found)) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control, stream state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            pos_reg            <= '0;
            matches_reg        <= '0;
            reported_reg       <= 1'b0;
            pos_ovf_reg        <= 1'b0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
            occurrence_reg     <= OCC_W'(1);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                if (in_last_reg) begin
                    // end of text: fresh state for the next one
                    pos_reg      <= '0;
                    matches_reg  <= '0;
                    reported_reg <= 1'b0;
                    pos_ovf_reg  <= 1'b0;
                end else begin
                    pos_reg      <= pos_next;
                    matches_reg  <= matches_next;
                    reported_reg <= reported_next;
                    pos_ovf_reg  <= pos_ovf_next;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                    REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                    REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                    REG_OCCURRENCE:     occurrence_reg     <= cfg_wdata[OCC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // history window, cleared at reset and at each end of text
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WIN_SLOTS; k++) begin
                history_reg[k] <= '0;
            end
        end else if (advance) begin
            if (in_last_reg) begin
                for (int k = 0; k < WIN_SLOTS; k++) begin
                    history_reg[k] <= '0;
                end
            end else if (PATTERN_MAX > 1) begin
                for (int k = WIN_SLOTS - 1; k > 0; k--) begin
                    history_reg[k] <= history_reg[k-1];
                end
                history_reg[0] <= in_byte_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance && (report || not_found)) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {2'b00, out_reg.overflow, out_reg.match_length, out_reg.match_offset};

endmodule

### src/nsf_checker.sv
module nsf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nsf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import nsf_pkg::*;

    // a waiting result holds still
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // not found carries zero offset and zero length
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OFF_W+LEN_W-1:0] == '0)
        else $error("not-found result with nonzero offset or length");

    // a found result always has a pattern length
    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OFF_W+LEN_W-1:OFF_W] != '0)
        else $error("found result with zero length");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind nth_substring_finder_top nsf_checker u_nsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
